/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain condition checked every cycle outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// types and constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 30;

    localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] quat_scalar;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        branch_t            branch_taken;
        logic               degenerate;
    } quat_t;

    // off-diagonal pair terms carried down the pipeline
    typedef struct packed {
        logic signed [32:0] pa;
        logic signed [32:0] pb;
        logic signed [32:0] pc;
    } pairs_t;

    typedef struct packed {
        branch_t branch;
        logic    degen;
    } ctl_t;

endpackage

/* rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: fully pipelined, one transaction per cycle
// one root bit per stage in the square root, one quotient bit per divide stage
// busy stays low; done strobes for one cycle per transaction; async reset clears valids
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rmq_pkg::matrix_t matrix,
    output logic            done,
    output rmq_pkg::quat_t  quat
);

    localparam int RADW     = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 2;
    localparam int SQ_PAIRS = (RADW + FRAC_BITS) / 2;
    localparam int NW       = 2 * SQ_PAIRS;
    localparam int SRW      = SQ_PAIRS + 2;
    localparam int DENW     = SQ_PAIRS + 1;
    localparam int NUMW     = 33 + FRAC_BITS;
    localparam int DIVN     = NUMW;
    localparam int DGW      = SQ_PAIRS - 1;
    localparam int EW       = DGW + 32;

    // input register
    logic             in_v_reg;
    rmq_pkg::matrix_t in_reg;

    // branch select stage
    logic                   b_v_reg;
    rmq_pkg::ctl_t          b_ctl_reg;
    logic signed [RADW-1:0] b_rad_reg;
    rmq_pkg::pairs_t        b_pairs_reg;

    // square root stages, entry 0 loaded from branch stage
    logic            sq_v_reg     [0:SQ_PAIRS];
    rmq_pkg::ctl_t   sq_ctl_reg   [0:SQ_PAIRS];
    rmq_pkg::pairs_t sq_pairs_reg [0:SQ_PAIRS];
    logic [NW-1:0]       sq_n_reg    [0:SQ_PAIRS];
    logic [SRW-1:0]      sq_rem_reg  [0:SQ_PAIRS];
    logic [SQ_PAIRS-1:0] sq_root_reg [0:SQ_PAIRS];

    // divide stages, three lanes
    logic            dv_v_reg    [0:DIVN];
    rmq_pkg::ctl_t   dv_ctl_reg  [0:DIVN];
    logic [31:0]     dv_diag_reg [0:DIVN];
    logic [DENW-1:0] dv_den_reg  [0:DIVN];
    logic            dv_neg_reg  [0:DIVN][0:2];
    logic [NUMW-1:0] dv_num_reg  [0:DIVN][0:2];
    logic [SRW-1:0]  dv_rem_reg  [0:DIVN][0:2];
    logic [31:0]     dv_q_reg    [0:DIVN][0:2];
    logic            dv_ovf_reg  [0:DIVN][0:2];

    logic           out_v_reg;
    rmq_pkg::quat_t out_reg;
    rmq_pkg::quat_t out_next;

    assign busy = 1'b0;
    assign done = out_v_reg;
    assign quat = out_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= matrix;
    end

    // branch choice and radicand
    logic signed [33:0]     trace;
    logic signed [RADW-1:0] one_ext;
    logic signed [RADW-1:0] e00;
    logic signed [RADW-1:0] e11;
    logic signed [RADW-1:0] e22;
    rmq_pkg::branch_t       b_branch_next;
    logic signed [RADW-1:0] b_rad_next;
    rmq_pkg::pairs_t        b_pairs_next;

    always_comb
    begin
        trace = 34'(in_reg.m00) + 34'(in_reg.m11) + 34'(in_reg.m22);
        one_ext = RADW'(1) <<< FRAC_BITS;
        e00 = RADW'(in_reg.m00);
        e11 = RADW'(in_reg.m11);
        e22 = RADW'(in_reg.m22);
        if (trace > 34'sd0)
        begin
            b_branch_next   = rmq_pkg::BR_TRACE;
            b_rad_next      = one_ext + e00 + e11 + e22;
            b_pairs_next.pa = 33'(in_reg.m12) - 33'(in_reg.m21);
            b_pairs_next.pb = 33'(in_reg.m20) - 33'(in_reg.m02);
            b_pairs_next.pc = 33'(in_reg.m01) - 33'(in_reg.m10);
        end
        else if (in_reg.m00 > in_reg.m11 && in_reg.m00 > in_reg.m22)
        begin
            b_branch_next   = rmq_pkg::BR_X;
            b_rad_next      = one_ext + e00 - e11 - e22;
            b_pairs_next.pa = 33'(in_reg.m12) - 33'(in_reg.m21);
            b_pairs_next.pb = 33'(in_reg.m10) + 33'(in_reg.m01);
            b_pairs_next.pc = 33'(in_reg.m20) + 33'(in_reg.m02);
        end
        else if (in_reg.m11 > in_reg.m22)
        begin
            b_branch_next   = rmq_pkg::BR_Y;
            b_rad_next      = one_ext + e11 - e00 - e22;
            b_pairs_next.pa = 33'(in_reg.m20) - 33'(in_reg.m02);
            b_pairs_next.pb = 33'(in_reg.m10) + 33'(in_reg.m01);
            b_pairs_next.pc = 33'(in_reg.m21) + 33'(in_reg.m12);
        end
        else
        begin
            b_branch_next   = rmq_pkg::BR_Z;
            b_rad_next      = one_ext + e22 - e00 - e11;
            b_pairs_next.pa = 33'(in_reg.m01) - 33'(in_reg.m10);
            b_pairs_next.pb = 33'(in_reg.m20) + 33'(in_reg.m02);
            b_pairs_next.pc = 33'(in_reg.m21) + 33'(in_reg.m12);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ctl_reg.branch <= b_branch_next;
        b_ctl_reg.degen  <= 1'b0;
        b_rad_reg        <= b_rad_next;
        b_pairs_reg      <= b_pairs_next;
    end

    // clamp radicand and scale it for the root
    logic          rad_bad;
    logic [NW-1:0] sq_n_next;

    always_comb
    begin
        rad_bad   = (b_rad_reg <= RADW'(0));
        sq_n_next = rad_bad ? NW'(0) : (NW'(b_rad_reg[RADW-2:0]) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            sq_v_reg[0] <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_ctl_reg[0].branch <= b_ctl_reg.branch;
        sq_ctl_reg[0].degen  <= rad_bad;
        sq_pairs_reg[0]      <= b_pairs_reg;
        sq_n_reg[0]          <= sq_n_next;
        sq_rem_reg[0]        <= '0;
        sq_root_reg[0]       <= '0;
    end

    // square root, one root bit per stage
    for (genvar k = 0; k < SQ_PAIRS; k++)
    begin : g_sqrt
        logic [SRW-1:0]      rem_t;
        logic [SRW-1:0]      trial;
        logic [SRW-1:0]      rem_next;
        logic [SQ_PAIRS-1:0] root_next;

        always_comb
        begin
            rem_t = {sq_rem_reg[k][SRW-3:0], sq_n_reg[k][NW-1 -: 2]};
            trial = {sq_root_reg[k], 2'b01};
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {sq_root_reg[k][SQ_PAIRS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {sq_root_reg[k][SQ_PAIRS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_ctl_reg[k+1]   <= sq_ctl_reg[k];
            sq_pairs_reg[k+1] <= sq_pairs_reg[k];
            sq_n_reg[k+1]     <= {sq_n_reg[k][NW-3:0], 2'b00};
            sq_rem_reg[k+1]   <= rem_next;
            sq_root_reg[k+1]  <= root_next;
        end
    end

    // divider set-up: diagonal term, denominator, pair magnitudes
    logic [DGW-1:0]  diag_raw;
    logic [EW-1:0]   diag_ext;
    logic [31:0]     diag_next;
    logic [32:0]     pair_val [0:2];
    logic            pair_neg [0:2];
    logic [32:0]     pair_mag [0:2];

    always_comb
    begin
        diag_raw  = sq_root_reg[SQ_PAIRS][SQ_PAIRS-1:1];
        diag_ext  = EW'(diag_raw);
        diag_next = (diag_ext > EW'(rmq_pkg::QMAX)) ? 32'(rmq_pkg::QMAX) : diag_ext[31:0];
        pair_val[0] = sq_pairs_reg[SQ_PAIRS].pa;
        pair_val[1] = sq_pairs_reg[SQ_PAIRS].pb;
        pair_val[2] = sq_pairs_reg[SQ_PAIRS].pc;
        for (int i = 0; i < 3; i++)
        begin
            pair_neg[i] = pair_val[i][32];
            pair_mag[i] = pair_neg[i] ? (33'd0 - pair_val[i]) : pair_val[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= sq_v_reg[SQ_PAIRS];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_ctl_reg[0]  <= sq_ctl_reg[SQ_PAIRS];
        dv_diag_reg[0] <= diag_next;
        dv_den_reg[0]  <= {sq_root_reg[SQ_PAIRS], 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            dv_neg_reg[0][i] <= pair_neg[i];
            dv_num_reg[0][i] <= {pair_mag[i], FRAC_BITS'(0)};
            dv_rem_reg[0][i] <= '0;
            dv_q_reg[0][i]   <= '0;
            dv_ovf_reg[0][i] <= 1'b0;
        end
    end

    // restoring divide, one quotient bit per stage in each lane
    for (genvar k = 0; k < DIVN; k++)
    begin : g_div
        logic [SRW-1:0] rem_t    [0:2];
        logic [SRW-1:0] rem_next [0:2];
        logic           qbit     [0:2];
        logic [SRW-1:0] den_ext;

        always_comb
        begin
            den_ext = SRW'(dv_den_reg[k]);
            for (int i = 0; i < 3; i++)
            begin
                rem_t[i] = {dv_rem_reg[k][i][SRW-2:0], dv_num_reg[k][i][NUMW-1]};
                qbit[i]  = (rem_t[i] >= den_ext);
                rem_next[i] = qbit[i] ? (rem_t[i] - den_ext) : rem_t[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_ctl_reg[k+1]  <= dv_ctl_reg[k];
            dv_diag_reg[k+1] <= dv_diag_reg[k];
            dv_den_reg[k+1]  <= dv_den_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                dv_neg_reg[k+1][i] <= dv_neg_reg[k][i];
                dv_num_reg[k+1][i] <= {dv_num_reg[k][i][NUMW-2:0], 1'b0};
                dv_rem_reg[k+1][i] <= rem_next[i];
                dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][30:0], qbit[i]};
                dv_ovf_reg[k+1][i] <= dv_ovf_reg[k][i] | dv_q_reg[k][i][31];
            end
        end
    end

    // saturation, sign and placement
    logic signed [31:0] comp [0:2];
    logic [31:0]        qv   [0:2];
    logic signed [31:0] diag_s;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = dv_q_reg[DIVN][i];
            if (dv_neg_reg[DIVN][i])
            begin
                if (dv_ovf_reg[DIVN][i] || qv[i] > 32'h8000_0000)
                begin
                    comp[i] = rmq_pkg::QMIN;
                end
                else
                begin
                    comp[i] = $signed(32'd0 - qv[i]);
                end
            end
            else
            begin
                if (dv_ovf_reg[DIVN][i] || qv[i][31])
                begin
                    comp[i] = rmq_pkg::QMAX;
                end
                else
                begin
                    comp[i] = $signed(qv[i]);
                end
            end
        end
        diag_s = $signed(dv_diag_reg[DIVN]);

        out_next.branch_taken = dv_ctl_reg[DIVN].branch;
        out_next.degenerate   = dv_ctl_reg[DIVN].degen;
        unique case (dv_ctl_reg[DIVN].branch)
            rmq_pkg::BR_TRACE:
            begin
                out_next.quat_scalar = diag_s;
                out_next.quat_x      = comp[0];
                out_next.quat_y      = comp[1];
                out_next.quat_z      = comp[2];
            end
            rmq_pkg::BR_X:
            begin
                out_next.quat_scalar = comp[0];
                out_next.quat_x      = diag_s;
                out_next.quat_y      = comp[1];
                out_next.quat_z      = comp[2];
            end
            rmq_pkg::BR_Y:
            begin
                out_next.quat_scalar = comp[0];
                out_next.quat_x      = comp[1];
                out_next.quat_y      = diag_s;
                out_next.quat_z      = comp[2];
            end
            default:
            begin
                out_next.quat_scalar = comp[0];
                out_next.quat_x      = comp[1];
                out_next.quat_y      = comp[2];
                out_next.quat_z      = diag_s;
            end
        endcase
        if (dv_ctl_reg[DIVN].degen)
        begin
            out_next.quat_scalar = '0;
            out_next.quat_x      = '0;
            out_next.quat_y      = '0;
            out_next.quat_z      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= dv_v_reg[DIVN];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // checks
    `ASSERT_IMPL(a_done_timing, done, $past(sq_v_reg[SQ_PAIRS], DIVN + 2), "done out of step")
    `ASSERT_IMPL(a_degen_zero, done && quat.degenerate, quat.quat_scalar == 32'sd0 && quat.quat_x == 32'sd0 && quat.quat_y == 32'sd0 && quat.quat_z == 32'sd0, "degenerate transaction with nonzero parts")
    `ASSERT_IMPL(a_trace_ok, done && quat.branch_taken == rmq_pkg::BR_TRACE, !quat.degenerate, "positive trace flagged degenerate")

endmodule
